FILE: rtl/competing_risk_log_likelihood_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the competing-risk log-likelihood block
// Property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef COMPETING_RISK_LOG_LIKELIHOOD_ASSERT_SVH
`define COMPETING_RISK_LOG_LIKELIHOOD_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRLL_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CRLL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/crll_pkg.sv
// ----------------------------------------------------------------------------
// crll_pkg
// Shared constants, unit interface types and saturating add.
// ----------------------------------------------------------------------------
`default_nettype none

package crll_pkg;

	localparam int MAX_SUBJECTS = 4096;
	localparam int IDX_W        = $clog2(MAX_SUBJECTS);
	localparam int CNT_W        = IDX_W + 1;

	localparam int FRAC_BITS = 16;
	localparam int IQ        = 31;
	localparam int XSH       = IQ - FRAC_BITS;

	localparam logic [30:0] LN2_Q31   = 31'd1488522236;
	localparam int          K_OFS     = 24;
	localparam logic [63:0] K_OFS_LN2 = 64'(K_OFS) * 64'(LN2_Q31);

	localparam int DIV_W   = 64;
	localparam int DEN_W   = 34;
	localparam int DCNT_W  = $clog2(DIV_W) + 1;

	localparam logic [1:0] ST_CENSORED  = 2'd0;
	localparam logic [1:0] ST_EVENT     = 2'd1;
	localparam logic [1:0] ST_COMPETING = 2'd2;
	localparam logic [1:0] ST_CENS_ALT  = 2'd3;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
		logic [DEN_W-1:0] rem;
	} div_rsp_t;

	// Returns {overflow, sum}; the sum sticks at all ones on overflow.
	function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[64]) begin
			s = {1'b1, {64{1'b1}}};
		end
		return s;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/crll_div.sv
// ----------------------------------------------------------------------------
// crll_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module crll_div (
	input  wire                 clk,
	input  wire                 arst_n,
	input  crll_pkg::div_req_t  req,
	output crll_pkg::div_rsp_t  rsp
);
	import crll_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;

	logic [DEN_W:0]    trial;
	logic [DEN_W+1:0]  diff;
	logic              ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = !diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				quo_q  <= req.num;
				rem_q  <= '0;
				den_q  <= req.den;
				cnt_q  <= DCNT_W'(DIV_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// shift in one quotient bit, keep the partial remainder
				quo_q <= {quo_q[DIV_W-2:0], ge};
				rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

FILE: rtl/crll_mul.sv
// ----------------------------------------------------------------------------
// crll_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module crll_mul (
	input  wire         clk,
	input  wire  [31:0] a,
	input  wire  [31:0] b,
	output logic [63:0] p
);
	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

`default_nettype wire

FILE: rtl/competing_risk_log_likelihood.sv
// ----------------------------------------------------------------------------
// competing_risk_log_likelihood
// Competing-risks log partial likelihood over a batch of sorted subjects.
// ----------------------------------------------------------------------------
// Subjects come in one item per start pulse, sorted by decreasing time; the
// item marked last_subject closes the batch, and one result follows on
// log_likelihood/saturated with a one-cycle done strobe. The receiver cannot
// stall: sample the result in the cycle done is high. An item is taken when
// start is high and busy is low; busy stays high while the item is worked on.
// All arithmetic runs on one sequencer around a shared 64-bit restoring
// divider and a shared 32x32 multiplier. Loading one subject costs one
// exp(): 14 divisions. After the last item three passes run over the stored
// subjects: a competing pass (an exp() and a division per competing event,
// two multiplies and an add per event of interest), a tie pass and a log
// pass (a normalize plus 12 divisions per event of interest). Subjects past
// MAX_SUBJECTS are dropped and set saturated. The subject memories need no
// clearing: only entries written in the current batch are read.
// ----------------------------------------------------------------------------
`default_nettype none

module competing_risk_log_likelihood (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire         [31:0] event_time,
	input  wire         [1:0]  status,
	input  wire  signed [20:0] linear_predictor,
	input  wire         [17:0] weight,
	input  wire                last_subject,
	output logic               done,
	output logic signed [47:0] log_likelihood,
	output logic               saturated
);
	import crll_pkg::*;

	typedef struct packed {
		logic        [31:0] t;
		logic        [1:0]  st;
		logic signed [20:0] eta;
		logic        [17:0] w;
	} subj_t;

	typedef enum logic [5:0] {
		S_IDLE,
		S_X_K, S_X_KW, S_X_M, S_X_MD, S_X_DW, S_X_SC,
		S_LD_FIN,
		S_C_RD, S_C_USE, S_C_DIV, S_C_DW, S_C_M1, S_C_M2, S_C_M3, S_C_ADD, S_C_NEXT,
		S_T_RD0, S_T_USE0, S_T_RD, S_T_USE,
		S_L_RD, S_L_USE, S_L_NEXT,
		S_G_NORM, S_G_Z, S_G_ZW, S_G_SQ, S_G_SQD, S_G_M, S_G_MD, S_G_DW, S_G_V, S_G_ACC,
		S_OUT
	} state_t;

	typedef enum logic {R_LOAD, R_COMP} ret_t;

	state_t state_q;
	ret_t   ret_q;

	// Per-item and working registers.
	logic        [31:0] t_q;
	logic        [1:0]  st_q;
	logic signed [20:0] eta_q;
	logic        [17:0] w_q;
	logic               last_q;
	logic signed [6:0]  k_q;
	logic        [30:0] r_q;
	logic        [31:0] term_q;
	logic        [31:0] z2_q;
	logic        [33:0] sum_q;
	logic        [4:0]  n_q;
	logic        [63:0] e_q;
	logic        [63:0] pa_q;
	logic        [63:0] rk_q;
	logic        [63:0] nrm_q;
	logic        [5:0]  m_q;
	logic signed [41:0] v_q;

	// Batch state.
	logic        [63:0]      back_q;
	logic        [63:0]      comp_q;
	logic signed [49:0]      acc_q;
	logic        [CNT_W-1:0] cnt_q;
	logic        [IDX_W-1:0] idx_q;
	logic                    sat_q;

	// Result registers.
	logic               done_q;
	logic signed [47:0] ll_q;
	logic               sat_out_q;

	// Subject memories, single address, registered read.
	subj_t       subj_mem [MAX_SUBJECTS];
	logic [63:0] risk_mem [MAX_SUBJECTS];
	subj_t       subj_rd_q;
	logic [63:0] risk_rd_q;
	logic        subj_we;
	subj_t       subj_wd;
	logic        risk_we;
	logic [63:0] risk_wd;

	always_ff @(posedge clk) begin
		if (subj_we) begin
			subj_mem[idx_q] <= subj_wd;
		end
		if (risk_we) begin
			risk_mem[idx_q] <= risk_wd;
		end
		subj_rd_q <= subj_mem[idx_q];
		risk_rd_q <= risk_mem[idx_q];
	end

	// Shared units.
	div_req_t    div_req;
	div_rsp_t    div_rsp;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;

	crll_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	crll_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// Datapath terms.
	logic [63:0] x_num;
	logic [63:0] p_rnd;
	logic [31:0] t1;
	logic [31:0] y;
	logic [32:0] yp1;
	logic [64:0] back_add;
	logic [64:0] comp_add;
	logic [64:0] rk_add;
	logic [64:0] mul_add;
	logic [48:0] mul_lo;
	logic signed [7:0] sh;
	logic [5:0]  ns;
	logic [63:0] exp_val;
	logic        exp_ovf;
	logic signed [7:0]  mm;
	logic signed [41:0] v_next;
	logic [41:0] v_mag;
	logic [26:0] l_mag;
	logic        tie_hit;
	logic        acc_hi;
	logic        acc_lo;

	// eta in Q31, biased up by K_OFS*ln2 so the range reduction divides a
	// non-negative value; the remainder is then r and the quotient k+K_OFS.
	assign x_num = {{(64 - 21 - XSH){eta_q[20]}}, eta_q, {XSH{1'b0}}} + K_OFS_LN2;

	assign p_rnd = mul_p + (64'd1 << (IQ - 1));
	assign t1    = p_rnd[62:31];

	assign y   = nrm_q[63:32];
	assign yp1 = {1'b0, y} + (33'd1 << IQ);

	assign back_add = sat_add(back_q, e_q);
	assign comp_add = sat_add(comp_q, div_rsp.quo);
	assign rk_add   = sat_add(rk_q, e_q);
	assign mul_lo   = 49'((mul_p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
	assign mul_add  = sat_add({pa_q[47:0], {FRAC_BITS{1'b0}}}, 64'(mul_lo));

	// Final scale of the Taylor sum by 2^(k+FRAC_BITS-IQ), rounded.
	assign sh = {k_q[6], k_q} - 8'sd15;
	assign ns = 6'(-sh);
	always_comb begin
		exp_ovf = 1'b0;
		exp_val = '0;
		if (sh > 8'sd31) begin
			exp_ovf = 1'b1;
			exp_val = {64{1'b1}};
		end else if (!sh[7]) begin
			exp_val = 64'(sum_q) << sh[4:0];
		end else if (sh >= -8'sd40) begin
			exp_val = (64'(sum_q) + (64'd1 << (ns - 6'd1))) >> ns;
		end
	end

	assign mm     = 8'(signed'({2'b00, m_q})) - 8'sd16;
	assign v_next = $signed({7'b0, sum_q, 1'b0})
		+ 42'(mm) * 42'(signed'({1'b0, LN2_Q31}));
	assign v_mag  = v_q[41] ? 42'(-v_q) : v_q;
	assign l_mag  = 27'((v_mag + (42'd1 << (XSH - 1))) >> XSH);

	assign tie_hit = (st_q == ST_EVENT) && (subj_rd_q.st == ST_EVENT)
		&& (t_q == subj_rd_q.t);

	assign acc_hi = !acc_q[49] && (acc_q[48:47] != 2'b00);
	assign acc_lo =  acc_q[49] && (acc_q[48:47] != 2'b11);

	// Unit operands and memory writes follow the state.
	always_comb begin
		div_req = '0;
		mul_a   = '0;
		mul_b   = '0;
		subj_we = 1'b0;
		subj_wd = '{t: t_q, st: st_q, eta: eta_q, w: w_q};
		risk_we = 1'b0;
		risk_wd = '0;
		case (state_q)
			S_X_K: begin
				div_req = '{start: 1'b1, num: x_num, den: DEN_W'(LN2_Q31)};
			end
			S_X_M: begin
				mul_a = term_q;
				mul_b = {1'b0, r_q};
			end
			S_X_MD, S_G_MD: begin
				div_req = '{start: 1'b1, num: 64'(t1) + 64'(n_q >> 1), den: DEN_W'(n_q)};
			end
			S_LD_FIN: begin
				subj_we = 1'b1;
				risk_we = 1'b1;
				risk_wd = (st_q == ST_EVENT) ? back_add[63:0] : 64'd0;
			end
			S_C_DIV: begin
				div_req = '{start: 1'b1,
					num: {e_q[63-FRAC_BITS:0], {FRAC_BITS{1'b0}}} + 64'(w_q >> 1),
					den: DEN_W'(w_q)};
			end
			S_C_M1: begin
				mul_a = 32'(w_q);
				mul_b = comp_q[63:32];
			end
			S_C_M2: begin
				mul_a = 32'(w_q);
				mul_b = comp_q[31:0];
			end
			S_C_ADD: begin
				risk_we = 1'b1;
				risk_wd = rk_add[63:0];
			end
			S_T_USE: begin
				risk_we = tie_hit;
				risk_wd = rk_q;
			end
			S_G_Z: begin
				div_req = '{start: 1'b1,
					num: {2'b00, y[30:0], 31'd0} + 64'(yp1 >> 1),
					den: DEN_W'(yp1)};
			end
			S_G_SQ: begin
				mul_a = term_q;
				mul_b = term_q;
			end
			S_G_M: begin
				mul_a = term_q;
				mul_b = z2_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= R_LOAD;
			t_q       <= '0;
			st_q      <= '0;
			eta_q     <= '0;
			w_q       <= '0;
			last_q    <= 1'b0;
			k_q       <= '0;
			r_q       <= '0;
			term_q    <= '0;
			z2_q      <= '0;
			sum_q     <= '0;
			n_q       <= '0;
			e_q       <= '0;
			pa_q      <= '0;
			rk_q      <= '0;
			nrm_q     <= '0;
			m_q       <= '0;
			v_q       <= '0;
			back_q    <= '0;
			comp_q    <= '0;
			acc_q     <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
			sat_q     <= 1'b0;
			done_q    <= 1'b0;
			ll_q      <= '0;
			sat_out_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						t_q    <= event_time;
						st_q   <= status;
						eta_q  <= linear_predictor;
						w_q    <= (weight == 18'd0) ? 18'd1 : weight;
						last_q <= last_subject;
						if (!cnt_q[CNT_W-1]) begin
							// room left: store this subject after its exp()
							idx_q   <= cnt_q[IDX_W-1:0];
							ret_q   <= R_LOAD;
							state_q <= S_X_K;
						end else begin
							// batch full: drop the subject
							sat_q <= 1'b1;
							if (last_subject) begin
								idx_q   <= IDX_W'(cnt_q - 1'b1);
								state_q <= S_C_RD;
							end
						end
					end
				end

				// exp(eta): range reduction, 13 Taylor terms, final scale
				S_X_K: begin
					state_q <= S_X_KW;
				end
				S_X_KW: begin
					if (div_rsp.done) begin
						k_q     <= 7'(div_rsp.quo[6:0]) - 7'(K_OFS);
						r_q     <= div_rsp.rem[30:0];
						term_q  <= 32'd1 << IQ;
						sum_q   <= 34'd1 << IQ;
						n_q     <= 5'd1;
						state_q <= S_X_M;
					end
				end
				S_X_M: begin
					state_q <= S_X_MD;
				end
				S_X_MD: begin
					state_q <= S_X_DW;
				end
				S_X_DW: begin
					if (div_rsp.done) begin
						term_q <= div_rsp.quo[31:0];
						sum_q  <= sum_q + 34'(div_rsp.quo[31:0]);
						if (n_q == 5'd13) begin
							state_q <= S_X_SC;
						end else begin
							n_q     <= n_q + 5'd1;
							state_q <= S_X_M;
						end
					end
				end
				S_X_SC: begin
					e_q     <= exp_val;
					sat_q   <= sat_q | exp_ovf;
					state_q <= (ret_q == R_LOAD) ? S_LD_FIN : S_C_DIV;
				end

				// store the subject, advance the backward sum
				S_LD_FIN: begin
					back_q <= back_add[63:0];
					sat_q  <= sat_q | back_add[64];
					if (st_q == ST_EVENT) begin
						acc_q <= acc_q + 50'(eta_q);
					end
					cnt_q   <= cnt_q + 1'b1;
					state_q <= last_q ? S_C_RD : S_IDLE;
				end

				// competing pass, last index down to zero
				S_C_RD: begin
					state_q <= S_C_USE;
				end
				S_C_USE: begin
					eta_q <= subj_rd_q.eta;
					w_q   <= subj_rd_q.w;
					rk_q  <= risk_rd_q;
					if (subj_rd_q.st == ST_COMPETING) begin
						ret_q   <= R_COMP;
						state_q <= S_X_K;
					end else if (subj_rd_q.st == ST_EVENT) begin
						state_q <= S_C_M1;
					end else begin
						state_q <= S_C_NEXT;
					end
				end
				S_C_DIV: begin
					state_q <= S_C_DW;
				end
				S_C_DW: begin
					if (div_rsp.done) begin
						comp_q  <= comp_add[63:0];
						sat_q   <= sat_q | comp_add[64];
						state_q <= S_C_NEXT;
					end
				end
				S_C_M1: begin
					state_q <= S_C_M2;
				end
				S_C_M2: begin
					pa_q    <= mul_p;
					state_q <= S_C_M3;
				end
				S_C_M3: begin
					if (pa_q[63:48] != 16'd0) begin
						e_q   <= {64{1'b1}};
						sat_q <= 1'b1;
					end else begin
						e_q   <= mul_add[63:0];
						sat_q <= sat_q | mul_add[64];
					end
					state_q <= S_C_ADD;
				end
				S_C_ADD: begin
					sat_q   <= sat_q | rk_add[64];
					state_q <= S_C_NEXT;
				end
				S_C_NEXT: begin
					if (idx_q == '0) begin
						idx_q   <= IDX_W'(cnt_q - 1'b1);
						state_q <= (cnt_q > CNT_W'(1)) ? S_T_RD0 : S_L_RD;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= S_C_RD;
					end
				end

				// tie pass: hold the later entry, copy its risk sum down a tie
				S_T_RD0: begin
					state_q <= S_T_USE0;
				end
				S_T_USE0: begin
					st_q    <= subj_rd_q.st;
					t_q     <= subj_rd_q.t;
					rk_q    <= risk_rd_q;
					idx_q   <= idx_q - 1'b1;
					state_q <= S_T_RD;
				end
				S_T_RD: begin
					state_q <= S_T_USE;
				end
				S_T_USE: begin
					if (!tie_hit) begin
						rk_q <= risk_rd_q;
					end
					st_q <= subj_rd_q.st;
					t_q  <= subj_rd_q.t;
					if (idx_q == '0) begin
						state_q <= S_L_RD;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= S_T_RD;
					end
				end

				// log pass, index zero upward
				S_L_RD: begin
					state_q <= S_L_USE;
				end
				S_L_USE: begin
					if (subj_rd_q.st == ST_EVENT) begin
						nrm_q   <= (risk_rd_q == 64'd0) ? 64'd1 : risk_rd_q;
						m_q     <= 6'd63;
						state_q <= S_G_NORM;
					end else begin
						state_q <= S_L_NEXT;
					end
				end
				S_L_NEXT: begin
					if (idx_q == IDX_W'(cnt_q - 1'b1)) begin
						state_q <= S_OUT;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_L_RD;
					end
				end

				// ln(R): normalize, z = (y-1)/(y+1), odd atanh series
				S_G_NORM: begin
					if (nrm_q[63]) begin
						state_q <= S_G_Z;
					end else begin
						nrm_q <= {nrm_q[62:0], 1'b0};
						m_q   <= m_q - 6'd1;
					end
				end
				S_G_Z: begin
					state_q <= S_G_ZW;
				end
				S_G_ZW: begin
					if (div_rsp.done) begin
						term_q  <= div_rsp.quo[31:0];
						sum_q   <= 34'(div_rsp.quo[31:0]);
						state_q <= S_G_SQ;
					end
				end
				S_G_SQ: begin
					state_q <= S_G_SQD;
				end
				S_G_SQD: begin
					z2_q    <= t1;
					n_q     <= 5'd3;
					state_q <= S_G_M;
				end
				S_G_M: begin
					state_q <= S_G_MD;
				end
				S_G_MD: begin
					term_q  <= t1;
					state_q <= S_G_DW;
				end
				S_G_DW: begin
					if (div_rsp.done) begin
						sum_q <= sum_q + 34'(div_rsp.quo[31:0]);
						if (n_q == 5'd23) begin
							state_q <= S_G_V;
						end else begin
							n_q     <= n_q + 5'd2;
							state_q <= S_G_M;
						end
					end
				end
				S_G_V: begin
					v_q     <= v_next;
					state_q <= S_G_ACC;
				end
				S_G_ACC: begin
					// subtract ln(R), rounded half away from zero
					if (v_q[41]) begin
						acc_q <= acc_q + 50'(l_mag);
					end else begin
						acc_q <= acc_q - 50'(l_mag);
					end
					state_q <= S_L_NEXT;
				end

				// deliver the result, clear the batch
				S_OUT: begin
					done_q    <= 1'b1;
					ll_q      <= acc_hi ? 48'sh7FFF_FFFF_FFFF :
						acc_lo ? 48'sh8000_0000_0000 : acc_q[47:0];
					sat_out_q <= sat_q | acc_hi | acc_lo;
					back_q    <= '0;
					comp_q    <= '0;
					acc_q     <= '0;
					cnt_q     <= '0;
					sat_q     <= 1'b0;
					state_q   <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign log_likelihood = ll_q;
	assign saturated      = sat_out_q;

endmodule

`default_nettype wire

FILE: rtl/crll_checker.sv
// ----------------------------------------------------------------------------
// crll_checker
// Port-level checks on the result strobe and busy handshake.
// ----------------------------------------------------------------------------
`default_nettype none

`include "competing_risk_log_likelihood_assert.svh"

module crll_checker (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire last_subject,
	input wire done
);

	`CRLL_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "done held past one cycle")
	`CRLL_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy, "done while busy")
	`CRLL_ASSERT_IMPL(a_done_after_work, clk, arst_n, done, $past(busy), "done without work")
	`CRLL_ASSERT_NEXT(a_last_busy, clk, arst_n, start && !busy && last_subject, busy, "last item not processed")

endmodule

bind competing_risk_log_likelihood crll_checker u_crll_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_subject (last_subject),
	.done         (done)
);

`default_nettype wire
